// ===== hw/rtl/bifh_pkg.sv =====
package bifh_pkg;

  // FNV-64 offset basis
  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_HASHES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_MODE  = 2'd2;

  localparam int CFG_DATA_W = 31;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       key_last;
  } in_item_t;

  typedef struct packed {
    logic [30:0] bit_index;
    logic [5:0]  hash_number;
    logic        last_index;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FOLD,
    ST_LOAD,
    ST_START,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

// ===== hw/rtl/bifh_fnv.sv =====
// One FNV-64 byte fold; the prime multiply is a sum of shifted copies
module bifh_fnv (
  input  logic [63:0] hash_in,
  input  logic [7:0]  data_byte,
  input  logic        mode,
  output logic [63:0] hash_out
);
  logic [63:0] pre;
  logic [63:0] prod;

  always_comb begin
    // FNV-1a xors the byte in before the multiply
    pre = mode ? (hash_in ^ {56'd0, data_byte}) : hash_in;
    // prime 0x100000001b3 = 2^40 + 2^8 + 2^7 + 2^5 + 2^4 + 2^1 + 1
    prod = (pre << 40) + (pre << 8) + (pre << 7) + (pre << 5)
         + (pre << 4) + (pre << 1) + pre;
    hash_out = mode ? prod : (prod ^ {56'd0, data_byte});
  end

endmodule

// ===== hw/rtl/bifh_mod.sv =====
// Restoring remainder unit: 32-bit dividend, 31-bit divisor, one bit per cycle
module bifh_mod (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [30:0] divisor,
  output logic        done,
  output logic [30:0] rem
);
  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [31:0] q_r;
  logic [30:0] rem_r;
  logic [30:0] d_r;
  logic [31:0] cur;
  logic [32:0] diff;
  logic [30:0] rem_nxt;

  // trial subtract of the divisor from the shifted partial remainder
  always_comb begin
    cur     = {rem_r, q_r[31]};
    diff    = {1'b0, cur} - {2'b00, d_r};
    rem_nxt = diff[32] ? cur[30:0] : diff[30:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy_r) begin
      q_r   <= q_r << 1;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== hw/rtl/bloom_index_fnv64_hash_top.sv =====
// Bloom index generator over a 64-bit FNV hash.
// Input channel in_valid/in_stall/in_data carries one key byte per item;
// byte_valid=0 items fold nothing, key_last marks the key's final item.
// Result channel out_valid/out_stall/out_data gives k indices per key,
// hash_number 0..k-1, last_index on the final one.
// Configuration: cfg_we/cfg_index/cfg_data, written only while idle, a rule
// on the user that the block itself does not enforce; index 0 num_hashes,
// 1 table_size, 2 hash_mode, others ignored. Each input item is accepted,
// then folded. After the key's last item come a load state, then per index
// a start state, the bit-serial remainder steps, a result register step
// and an output state held while out_stall is high.
// One item at a time: in_stall is high from acceptance until the item is
// folded or, after a key's last item, until its last result is taken.
// A stalled result holds out_data and blocks the next index. Reset (rst_n
// low, synchronous) returns the hash to the offset basis and the registers
// to num_hashes 1, table_size 1, mode 0.
module bloom_index_fnv64_hash_top #(
  parameter int MAX_HASHES = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  bifh_pkg::in_item_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output bifh_pkg::out_item_t                   out_data,
  input  logic                                  cfg_we,
  input  logic [bifh_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bifh_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import bifh_pkg::*;

  state_t      state_r, state_nxt;
  logic [6:0]  num_hashes_r;
  logic [30:0] table_size_r;
  logic        hash_mode_r;
  logic [63:0] hash_r;
  logic [63:0] hash_fold;
  in_item_t    item_r;
  logic [31:0] acc_r;
  logic [31:0] lo_r;
  logic [5:0]  idx_r;
  logic [5:0]  kmax_r;
  logic [30:0] m_r;
  out_item_t   out_r;
  logic [6:0]  k_eff;
  logic        mod_start;
  logic        mod_done;
  logic [30:0] mod_rem;
  logic        in_acc;
  logic        out_acc;

  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_data  = out_r;
  assign mod_start = (state_r == ST_START);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_hashes_r <= 7'd1;
      table_size_r <= 31'd1;
      hash_mode_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NUM_HASHES: num_hashes_r <= cfg_data[6:0];
        CFG_TABLE_SIZE: table_size_r <= cfg_data;
        CFG_HASH_MODE:  hash_mode_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clamp k into 1..MAX_HASHES
  always_comb begin
    if (num_hashes_r == 7'd0) k_eff = 7'd1;
    else if (num_hashes_r > 7'(MAX_HASHES)) k_eff = 7'(MAX_HASHES);
    else k_eff = num_hashes_r;
  end

  bifh_fnv u_fnv (
    .hash_in   (hash_r),
    .data_byte (item_r.data_byte),
    .mode      (hash_mode_r),
    .hash_out  (hash_fold)
  );

  bifh_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (acc_r),
    .divisor  (m_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = ST_FOLD;
      ST_FOLD:  state_nxt = item_r.key_last ? ST_LOAD : ST_IDLE;
      ST_LOAD:  state_nxt = ST_START;
      ST_START: state_nxt = ST_DIV;
      ST_DIV:   if (mod_done) state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_acc) state_nxt = (idx_r == kmax_r) ? ST_IDLE : ST_START;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // running hash and index counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= FNV_BASIS;
      idx_r  <= '0;
    end else begin
      if (state_r == ST_FOLD && item_r.byte_valid) hash_r <= hash_fold;
      if (state_r == ST_LOAD) idx_r <= '0;
      if (state_r == ST_OUT && out_acc) begin
        if (idx_r == kmax_r) begin
          hash_r <= FNV_BASIS;
          idx_r  <= '0;
        end else begin
          idx_r <= idx_r + 6'd1;
        end
      end
    end
  end

  // payload: item capture, composite sum, result register
  always_ff @(posedge clk) begin
    if (in_acc) item_r <= in_data;
    if (state_r == ST_LOAD) begin
      acc_r  <= hash_r[63:32];
      lo_r   <= hash_r[31:0];
      kmax_r <= 6'(k_eff - 7'd1);
      m_r    <= (table_size_r == 31'd0) ? 31'd1 : table_size_r;
    end
    // sum(i+1) = sum(i) + lo + 2i + 1, wrapping at 32 bits
    if (state_r == ST_OUT && out_acc)
      acc_r <= acc_r + lo_r + {25'd0, idx_r, 1'b1};
    if (state_r == ST_DIV && mod_done) begin
      out_r.bit_index   <= mod_rem;
      out_r.hash_number <= idx_r;
      out_r.last_index  <= (idx_r == kmax_r);
    end
  end

`ifndef SYNTHESIS
  a_fold_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_FOLD)
    else $error("accepted item not folded next cycle");

  a_hash_reset_after_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && out_data.last_index |=> hash_r == FNV_BASIS)
    else $error("hash not returned to basis after last index");

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.bit_index < m_r)
    else $error("bit_index not below table size");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last_index == (out_data.hash_number == kmax_r)))
    else $error("last_index does not match hash_number");
`endif

endmodule

// ===== bench/tb_bloom_index_fnv64_hash_top.sv =====
module tb_bloom_index_fnv64_hash_top;
  import bifh_pkg::*;

  localparam int MAX_HASHES = 64;
  localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 400;
  localparam int RAND_ITEMS = 120;

  // register settings used by the directed part
  typedef struct packed {
    logic [6:0]  k;
    logic [30:0] m;
    logic        mode;
  } cfg_set_t;

  localparam logic [2:0] CS_HEAVY = 3'd0;
  localparam logic [2:0] CS_ZERO  = 3'd1;
  localparam logic [2:0] CS_SMALL = 3'd2;
  localparam logic [2:0] NO_CFG   = 3'd7;

  localparam cfg_set_t CFG_SETS [3] = '{
    '{7'd127, 31'h7fffffff, 1'b1},  // k saturates to 64, widest table, FNV-1a
    '{7'd0,   31'd0,        1'b0},  // k and m both read as 1
    '{7'd3,   31'd1000,     1'b0}
  };

  // with a single-bit table every index is 0 and k is 1
  localparam out_item_t ONE_ZERO = '{31'd0, 6'd0, 1'b1};

  typedef struct packed {
    logic [2:0] cfg_sel;
    in_item_t   item;
    logic       typed;
    out_item_t  want;
  } dir_row_t;

  localparam int NDIR = 20;
  localparam dir_row_t DIR_ROWS [NDIR] = '{
    // reset settings: k 1, m 1, FNV-1
    '{NO_CFG,   '{8'h00, 1'b0, 1'b1}, 1'b1, ONE_ZERO},  // empty key
    '{NO_CFG,   '{8'hff, 1'b1, 1'b0}, 1'b0, '0},
    '{NO_CFG,   '{8'h00, 1'b1, 1'b1}, 1'b1, ONE_ZERO},  // zero byte hashed on the last item
    '{NO_CFG,   '{8'hab, 1'b0, 1'b0}, 1'b0, '0},        // skipped byte
    '{NO_CFG,   '{8'h55, 1'b1, 1'b1}, 1'b1, ONE_ZERO},
    // 64 indices, widest table
    '{CS_HEAVY, '{8'h00, 1'b0, 1'b1}, 1'b0, '0},        // basis only
    '{NO_CFG,   '{8'hff, 1'b1, 1'b0}, 1'b0, '0},
    '{NO_CFG,   '{8'h00, 1'b1, 1'b0}, 1'b0, '0},
    '{NO_CFG,   '{8'h80, 1'b1, 1'b1}, 1'b0, '0},
    // zero count and zero table size
    '{CS_ZERO,  '{8'h7f, 1'b1, 1'b1}, 1'b1, ONE_ZERO},
    '{NO_CFG,   '{8'h00, 1'b0, 1'b1}, 1'b1, ONE_ZERO},
    // small table, three indices
    '{CS_SMALL, '{8'h61, 1'b1, 1'b0}, 1'b0, '0},
    '{NO_CFG,   '{8'h62, 1'b1, 1'b0}, 1'b0, '0},
    '{NO_CFG,   '{8'h63, 1'b1, 1'b1}, 1'b0, '0},
    '{NO_CFG,   '{8'h01, 1'b1, 1'b0}, 1'b0, '0},
    '{NO_CFG,   '{8'h00, 1'b0, 1'b0}, 1'b0, '0},
    '{NO_CFG,   '{8'hfe, 1'b1, 1'b0}, 1'b0, '0},
    '{NO_CFG,   '{8'h00, 1'b0, 1'b1}, 1'b0, '0},        // empty final item
    '{NO_CFG,   '{8'h00, 1'b1, 1'b1}, 1'b0, '0},
    '{NO_CFG,   '{8'hff, 1'b1, 1'b1}, 1'b0, '0}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // predictor state
  logic [63:0] key_hash = FNV_BASIS;
  logic [6:0]  cfg_k = 7'd1;
  logic [30:0] cfg_m = 31'd1;
  logic        cfg_mode = 1'b0;

  out_item_t key_indices[$];
  out_item_t pending_indices[$];

  int  n_fail = 0;
  int  n_checked = 0;
  int  n_items = 0;
  int  n_keys = 0;
  int  n_cfgs = 0;
  int  burst_left = 0;
  int  hold_left = 0;
  bit  hold_done = 0;
  bit  rand_phase = 0;

  bloom_index_fnv64_hash_top #(
    .MAX_HASHES(MAX_HASHES)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one FNV step, FNV-1 or FNV-1a
  function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [7:0] b,
                                           input logic fnv1a);
    if (fnv1a) return (h ^ {56'd0, b}) * FNV_PRIME;
    return (h * FNV_PRIME) ^ {56'd0, b};
  endfunction

  // folds one item into the hash; on the last item fills key_indices
  function automatic void predict_indices(input in_item_t it);
    logic [31:0] hi, lo, sum, m, i;
    int unsigned k;
    out_item_t r;
    key_indices = {};
    if (it.byte_valid) key_hash = fnv_fold(key_hash, it.data_byte, cfg_mode);
    if (it.key_last) begin
      k = (cfg_k == 0) ? 1 : (cfg_k > MAX_HASHES) ? MAX_HASHES : cfg_k;
      m = (cfg_m == 0) ? 32'd1 : {1'b0, cfg_m};
      hi = key_hash[63:32];
      lo = key_hash[31:0];
      for (int n = 0; n < k; n++) begin
        i = n;
        sum = hi + i * lo + i * i;
        r.bit_index = 31'(sum % m);
        r.hash_number = i[5:0];
        r.last_index = (n + 1 == k);
        key_indices.push_back(r);
      end
      key_hash = FNV_BASIS;
    end
  endfunction

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 7) == 0) return ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  // offer one item in bursts, then log its indices once it is taken
  task automatic send_item(input in_item_t it, input bit typed = 1'b0,
                           input out_item_t want = '0);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      repeat ($urandom_range(0, 5)) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    predict_indices(it);
    if (typed) pending_indices.push_back(want);
    else foreach (key_indices[j]) pending_indices.push_back(key_indices[j]);
    if (it.byte_valid || it.key_last) n_items++;
    if (it.key_last) n_keys++;
  endtask

  // stop sending and let the block drain completely
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_indices.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_NUM_HASHES: cfg_k = val[6:0];
      CFG_TABLE_SIZE: cfg_m = val;
      CFG_HASH_MODE:  cfg_mode = val[0];
      default: ;
    endcase
  endtask

  // all three registers plus a write to the unused index; upper bits of the count and mode writes are noise
  task automatic apply_cfg(input cfg_set_t c);
    logic [CFG_DATA_W-1:0] val;
    val = CFG_DATA_W'($urandom);
    val[6:0] = c.k;
    write_reg(CFG_NUM_HASHES, val);
    write_reg(CFG_TABLE_SIZE, c.m);
    val = CFG_DATA_W'($urandom);
    val[0] = c.mode;
    write_reg(CFG_HASH_MODE, val);
    write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
    n_cfgs++;
  endtask

  // receiver: changing stall styles, plus one long hold-off early in the random part
  initial begin : receiver
    int style;
    int style_left;
    int run_left;
    bit run_stall;
    out_stall = 1'b0;
    style = 0;
    style_left = 0;
    run_left = 0;
    run_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (style_left == 0) begin
        style = $urandom_range(0, 2);
        style_left = $urandom_range(20, 80);
      end
      style_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (rand_phase && !hold_done && out_valid) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        case (style)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 2) == 0);
          default: begin
            if (run_left == 0) begin
              run_stall = !run_stall;
              run_left = $urandom_range(1, 8);
            end
            run_left--;
            out_stall <= run_stall;
          end
        endcase
      end
    end
  end

  // compare every taken index with the oldest expectation
  always @(posedge clk) begin : check_indices
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_indices.size() == 0) begin
        n_fail++;
        $display("%0t: unexpected index, got %p", $time, out_data);
      end else begin
        want = pending_indices.pop_front();
        n_checked++;
        if (out_data.bit_index !== want.bit_index) begin
          n_fail++;
          $display("%0t: bit_index expected %0d got %0d", $time, want.bit_index,
                   out_data.bit_index);
        end
        if (out_data.hash_number !== want.hash_number) begin
          n_fail++;
          $display("%0t: hash_number expected %0d got %0d", $time, want.hash_number,
                   out_data.hash_number);
        end
        if (out_data.last_index !== want.last_index) begin
          n_fail++;
          $display("%0t: last_index expected %0d got %0d", $time, want.last_index,
                   out_data.last_index);
        end
      end
    end
  end

  // stimulus
  initial begin
    int rand_target;
    int keys_in_cfg;
    int len;
    cfg_set_t rc;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_NUM_HASHES;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int r = 0; r < NDIR; r++) begin
      if (DIR_ROWS[r].cfg_sel != NO_CFG) begin
        settle();
        apply_cfg(CFG_SETS[DIR_ROWS[r].cfg_sel]);
      end
      send_item(DIR_ROWS[r].item, DIR_ROWS[r].typed, DIR_ROWS[r].want);
    end

    // random keys; settings change between keys, never during the long hold-off
    rand_phase = 1'b1;
    rand_target = n_items + RAND_ITEMS;
    keys_in_cfg = 0;
    while (n_items < rand_target) begin
      if (keys_in_cfg <= 0 && hold_left == 0) begin
        case ($urandom_range(0, 9))
          0: rc.k = 7'd0;
          1: rc.k = 7'($urandom_range(64, 127));
          2: rc.k = 7'($urandom_range(7, 20));
          default: rc.k = 7'($urandom_range(1, 6));
        endcase
        case ($urandom_range(0, 5))
          0: rc.m = 31'd0;
          1: rc.m = 31'h7fffffff;
          2: rc.m = 31'($urandom_range(1, 16));
          3: rc.m = 31'd1 << $urandom_range(0, 30);
          default: rc.m = 31'($urandom);
        endcase
        rc.mode = 1'($urandom_range(0, 1));
        settle();
        apply_cfg(rc);
        keys_in_cfg = $urandom_range(1, 4);
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(0, 4);
      for (int b = 0; b < len; b++) begin
        if ($urandom_range(0, 7) == 0)
          send_item('{8'($urandom_range(0, 255)), 1'b0, 1'b0});
        send_item('{pick_byte(), 1'b1, 1'b0});
      end
      if ($urandom_range(0, 3) == 0) send_item('{8'($urandom_range(0, 255)), 1'b0, 1'b1});
      else send_item('{pick_byte(), 1'b1, 1'b1});
      keys_in_cfg--;
    end

    settle();
    repeat (40) @(posedge clk);
    $display("%0d items in %0d keys, %0d indices checked, %0d register settings",
             n_items, n_keys, n_checked, n_cfgs);
    $display("both hash modes, empty and skipped bytes, 1..64 indices, tables 1..2^31-1");
    if (n_fail == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // hard limit on run time
  initial begin
    #20_000_000;
    $display("timeout with %0d indices outstanding", pending_indices.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== bloom_index_fnv64_hash_top.f =====
hw/rtl/bifh_pkg.sv
hw/rtl/bifh_fnv.sv
hw/rtl/bifh_mod.sv
hw/rtl/bloom_index_fnv64_hash_top.sv
bench/tb_bloom_index_fnv64_hash_top.sv
